### rtl/drc_pkg.sv
// Shared types, constants and rectangle arithmetic for the dirty rectangle coalescer.
// Used by the controller, the datapath and the top level; depends on nothing.
package drc_pkg;

  localparam int MAX_RECTS = 32;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);

  localparam int X_W = 10;
  localparam int Y_W = 9;
  localparam int W_W = 11;
  localparam int H_W = 10;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_CUR,
    RD_NEXT,
    RD_TAIL
  } rd_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    grow;
    logic    cnt_dec;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    idx_clr;
    logic    idx_inc;
    rd_sel_t rd_sel;
    logic    wr_slot;
    logic    wr_append;
    logic    out_load;
    logic    out_last;
  } drc_cmd_t;

  typedef struct packed {
    logic touch;
    logic idx_last;
    logic cnt_zero;
    logic cnt_full;
    logic out_free;
  } drc_sts_t;

  // inclusive edges: touching counts
  function automatic logic rects_touch(input rect_t a, input rect_t b);
    logic [X_W+1:0] a_r;
    logic [X_W+1:0] b_r;
    logic [Y_W+1:0] a_b;
    logic [Y_W+1:0] b_b;
    a_r = {2'b00, a.x} + {1'b0, a.w};
    b_r = {2'b00, b.x} + {1'b0, b.w};
    a_b = {2'b00, a.y} + {1'b0, a.h};
    b_b = {2'b00, b.y} + {1'b0, b.h};
    return ({2'b00, a.x} <= b_r) && ({2'b00, b.x} <= a_r) &&
           ({2'b00, a.y} <= b_b) && ({2'b00, b.y} <= a_b);
  endfunction

  // bounding box, size saturated to the field range
  function automatic rect_t rect_grow(input rect_t acc, input rect_t o);
    logic [X_W+1:0] right;
    logic [X_W+1:0] oright;
    logic [Y_W+1:0] bottom;
    logic [Y_W+1:0] obottom;
    logic [X_W+1:0] nw;
    logic [Y_W+1:0] nh;
    rect_t          res;
    right   = {2'b00, acc.x} + {1'b0, acc.w};
    oright  = {2'b00, o.x} + {1'b0, o.w};
    bottom  = {2'b00, acc.y} + {1'b0, acc.h};
    obottom = {2'b00, o.y} + {1'b0, o.h};
    res.x   = (o.x < acc.x) ? o.x : acc.x;
    res.y   = (o.y < acc.y) ? o.y : acc.y;
    if (oright > right) right = oright;
    if (obottom > bottom) bottom = obottom;
    nw    = right - {2'b00, res.x};
    nh    = bottom - {2'b00, res.y};
    res.w = nw[X_W+1] ? {W_W{1'b1}} : nw[W_W-1:0];
    res.h = nh[Y_W+1] ? {H_W{1'b1}} : nh[H_W-1:0];
    return res;
  endfunction

endpackage

### rtl/drc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module drc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/drc_datapath.sv
// Datapath: rectangle table RAM, working rectangle, slot index, entry count
// and the result register. Depends on drc_pkg and drc_ram.
module drc_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  drc_pkg::drc_cmd_t      cmd,
  output drc_pkg::drc_sts_t      sts,
  input  logic [drc_pkg::X_W-1:0] in_rect_x,
  input  logic [drc_pkg::Y_W-1:0] in_rect_y,
  input  logic [drc_pkg::W_W-1:0] in_rect_width,
  input  logic [drc_pkg::H_W-1:0] in_rect_height,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [drc_pkg::X_W-1:0] out_x,
  output logic [drc_pkg::Y_W-1:0] out_y,
  output logic [drc_pkg::W_W-1:0] out_width,
  output logic [drc_pkg::H_W-1:0] out_height,
  output logic                   out_last
);

  drc_pkg::rect_t                 item_r, item_nxt;
  logic [drc_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [drc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  drc_pkg::rect_t                 res_r, res_nxt;
  logic                           res_last_r, res_last_nxt;
  logic                           out_valid_r, out_valid_nxt;

  drc_pkg::rect_t                 rd_data;
  logic [drc_pkg::IDX_W-1:0]      raddr;
  logic [drc_pkg::IDX_W-1:0]      waddr;
  drc_pkg::rect_t                 wdata;
  logic                           we;
  logic [drc_pkg::CNT_W-1:0]      tail;
  logic [drc_pkg::CNT_W-1:0]      idx_ext;

  assign tail    = cnt_r - drc_pkg::CNT_W'(1);
  assign idx_ext = {{(drc_pkg::CNT_W-drc_pkg::IDX_W){1'b0}}, idx_r};

  always_comb begin
    case (cmd.rd_sel)
      drc_pkg::RD_ZERO: raddr = '0;
      drc_pkg::RD_CUR:  raddr = idx_r;
      drc_pkg::RD_NEXT: raddr = idx_r + drc_pkg::IDX_W'(1);
      drc_pkg::RD_TAIL: raddr = tail[drc_pkg::IDX_W-1:0];
      default:          raddr = '0;
    endcase
  end

  assign we    = cmd.wr_slot | cmd.wr_append;
  assign waddr = cmd.wr_append ? cnt_r[drc_pkg::IDX_W-1:0] : idx_r;
  assign wdata = cmd.wr_append ? item_r : rd_data;

  drc_ram #(
    .WIDTH(drc_pkg::RECT_W),
    .DEPTH(drc_pkg::MAX_RECTS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_comb begin
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load_item) begin
      item_nxt.x = in_rect_x;
      item_nxt.y = in_rect_y;
      item_nxt.w = in_rect_width;
      item_nxt.h = in_rect_height;
    end else if (cmd.grow) begin
      item_nxt = drc_pkg::rect_grow(item_r, rd_data);
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + drc_pkg::IDX_W'(1);
    end
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = tail;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + drc_pkg::CNT_W'(1);
    end
    if (cmd.out_load) begin
      res_nxt       = rd_data;
      res_last_nxt  = cmd.out_last;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    res_last_r <= res_last_nxt;
  end

  assign sts.touch    = drc_pkg::rects_touch(item_r, rd_data);
  assign sts.idx_last = (idx_ext + drc_pkg::CNT_W'(1)) == cnt_r;
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.cnt_full = cnt_r == drc_pkg::CNT_W'(drc_pkg::MAX_RECTS);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_x      = res_r.x;
  assign out_y      = res_r.y;
  assign out_width  = res_r.w;
  assign out_height = res_r.h;
  assign out_last   = res_last_r;

endmodule

### rtl/drc_ctrl.sv
// Controller state machine: sequences table scans, folds, appends and flushes.
// Depends on drc_pkg; drives the datapath by command, reads its status.
module drc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  drc_pkg::drc_sts_t sts,
  output drc_pkg::drc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FOLD,
    ST_APPEND,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = drc_pkg::RD_CUR;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.rd_sel  = drc_pkg::RD_ZERO;
        cmd.idx_clr = 1'b1;
        if (in_valid) begin
          if (in_op == drc_pkg::OP_ADD) begin
            cmd.load_item = 1'b1;
            state_nxt     = sts.cnt_zero ? ST_APPEND : ST_SCAN;
          end else if (!sts.cnt_zero) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        cmd.wr_slot = 1'b1;
        if (sts.touch) begin
          cmd.grow    = 1'b1;
          cmd.cnt_dec = 1'b1;
          if (sts.idx_last) begin
            state_nxt = ST_APPEND;
          end else begin
            cmd.rd_sel = drc_pkg::RD_TAIL;
          end
        end else if (sts.idx_last) begin
          if (sts.cnt_full) begin
            cmd.idx_clr = 1'b1;
            cmd.rd_sel  = drc_pkg::RD_ZERO;
            state_nxt   = ST_FOLD;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = drc_pkg::RD_NEXT;
        end
      end
      ST_FOLD: begin
        cmd.grow = 1'b1;
        if (sts.idx_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_APPEND;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = drc_pkg::RD_NEXT;
        end
      end
      ST_APPEND: begin
        cmd.wr_append = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.rd_sel    = drc_pkg::RD_ZERO;
        state_nxt     = ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.idx_last;
          if (sts.idx_last) begin
            cmd.cnt_clr = 1'b1;
            cmd.rd_sel  = drc_pkg::RD_ZERO;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_sel  = drc_pkg::RD_NEXT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

endmodule

### rtl/dirty_rectangle_coalescer.sv
// Dirty rectangle coalescer: top level joining controller and datapath.
// Depends on drc_pkg, drc_ctrl, drc_datapath (and through it drc_ram).
//
// Input channel (in_valid/in_stall): one request per item. in_op add merges the
// rectangle into the table; in_op flush drains the table in slot order.
// Result channel (out_valid/out_stall): one request per flushed rectangle,
// out_last marks the final one of a flush. An add or an empty flush gives none.
// Add sequence, n = stored entries: the item is compared with the n entries in
// turn, one entry per cycle (a merge re-compares the slot but removes one entry),
// then appended; a full table with no merge first runs a fold pass over all
// MAX_RECTS entries that merges them into the item and empties the table. The
// table RAM has a single read port, so entries are read one at a time.
// A flush sends one rectangle per cycle while out_stall is low; out_valid rises
// once the flush state has loaded the first entry into the result register.
// in_stall is high while an item is at work. A stalled result sits in the
// output register and the drain pauses; once the final rectangle is loaded a
// new item may be taken while it waits.
// Reset (rst_n low, synchronous) empties the table and clears out_valid.
module dirty_rectangle_coalescer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [drc_pkg::X_W-1:0] in_rect_x,
  input  logic [drc_pkg::Y_W-1:0] in_rect_y,
  input  logic [drc_pkg::W_W-1:0] in_rect_width,
  input  logic [drc_pkg::H_W-1:0] in_rect_height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [drc_pkg::X_W-1:0] out_x,
  output logic [drc_pkg::Y_W-1:0] out_y,
  output logic [drc_pkg::W_W-1:0] out_width,
  output logic [drc_pkg::H_W-1:0] out_height,
  output logic                    out_last
);

  drc_pkg::drc_cmd_t cmd;
  drc_pkg::drc_sts_t sts;

  drc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op   (in_op),
    .sts     (sts),
    .cmd     (cmd)
  );

  drc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_width     (out_width),
    .out_height    (out_height),
    .out_last      (out_last)
  );

endmodule

### rtl/drc_checker.sv
// Port-level checks for the dirty rectangle coalescer, bound to the top level.
// Depends on the top level's port list and drc_pkg field widths.
module drc_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_op,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [drc_pkg::X_W-1:0] out_x,
  input logic [drc_pkg::Y_W-1:0] out_y,
  input logic [drc_pkg::W_W-1:0] out_width,
  input logic [drc_pkg::H_W-1:0] out_height,
  input logic                    out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_width) && $stable(out_height) && $stable(out_last))
    else $error("stalled result changed");

  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == drc_pkg::OP_ADD) |=> in_stall)
    else $error("add request did not occupy the block");

  a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a flush");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the block");

endmodule

bind dirty_rectangle_coalescer drc_checker u_drc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_width (out_width),
  .out_height(out_height),
  .out_last  (out_last)
);

### tb/drc_rect_checker.sv
// Checker for the dirty rectangle coalescer: watches both request channels, keeps its own
// copy of the rectangle table and compares every flushed rectangle against it.
// Depends on drc_pkg for field widths, MAX_RECTS, rect_t and the op codes.
module drc_rect_checker
  import drc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_op,
  input  logic [X_W-1:0]   in_rect_x,
  input  logic [Y_W-1:0]   in_rect_y,
  input  logic [W_W-1:0]   in_rect_width,
  input  logic [H_W-1:0]   in_rect_height,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [X_W-1:0]   out_x,
  input  logic [Y_W-1:0]   out_y,
  input  logic [W_W-1:0]   out_width,
  input  logic [H_W-1:0]   out_height,
  input  logic             out_last,
  output int unsigned      fail_count,
  output int unsigned      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W_SAT = (1 << W_W) - 1;
  localparam int unsigned H_SAT = (1 << H_W) - 1;

  typedef struct packed {
    rect_t r;
    logic  last;
  } drained_t;

  rect_t       dirty_tbl [MAX_RECTS];
  int unsigned dirty_cnt = 0;
  drained_t    drain_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // inclusive edges, right and bottom taken at full width
  function automatic logic rects_meet(input rect_t a, input rect_t b);
    int unsigned a_r;
    int unsigned a_b;
    int unsigned b_r;
    int unsigned b_b;
    a_r = a.x;
    a_r += a.w;
    a_b = a.y;
    a_b += a.h;
    b_r = b.x;
    b_r += b.w;
    b_b = b.y;
    b_b += b.h;
    return (a.x <= b_r) && (b.x <= a_r) && (a.y <= b_b) && (b.y <= a_b);
  endfunction

  function automatic rect_t bound_box(input rect_t a, input rect_t b);
    int unsigned lft;
    int unsigned top;
    int unsigned rgt;
    int unsigned btm;
    int unsigned b_r;
    int unsigned b_b;
    rect_t       res;
    lft = (b.x < a.x) ? b.x : a.x;
    top = (b.y < a.y) ? b.y : a.y;
    rgt = a.x;
    rgt += a.w;
    btm = a.y;
    btm += a.h;
    b_r = b.x;
    b_r += b.w;
    b_b = b.y;
    b_b += b.h;
    if (b_r > rgt) rgt = b_r;
    if (b_b > btm) btm = b_b;
    res.x = lft[X_W-1:0];
    res.y = top[Y_W-1:0];
    res.w = (rgt - lft > W_SAT) ? W_SAT[W_W-1:0] : W_W'(rgt - lft);
    res.h = (btm - top > H_SAT) ? H_SAT[H_W-1:0] : H_W'(btm - top);
    return res;
  endfunction

  // merge into the table; a merged slot takes the tail entry and is compared again
  function void table_add(input rect_t item);
    int unsigned i;
    rect_t       acc;
    acc = item;
    i   = 0;
    while (i < dirty_cnt) begin
      if (rects_meet(acc, dirty_tbl[i])) begin
        acc = bound_box(acc, dirty_tbl[i]);
        dirty_cnt--;
        dirty_tbl[i] = dirty_tbl[dirty_cnt];
      end else begin
        i++;
      end
    end
    if (dirty_cnt == MAX_RECTS) begin
      for (int unsigned k = 0; k < dirty_cnt; k++) acc = bound_box(acc, dirty_tbl[k]);
      dirty_cnt = 0;
    end
    dirty_tbl[dirty_cnt] = acc;
    dirty_cnt++;
  endfunction

  function void table_flush();
    drained_t d;
    for (int unsigned i = 0; i < dirty_cnt; i++) begin
      d.r    = dirty_tbl[i];
      d.last = (i + 1 == dirty_cnt);
      drain_q.push_back(d);
    end
    dirty_cnt = 0;
  endfunction

  always @(posedge clk) begin
    drained_t want;
    drained_t got;
    if (!rst_n) begin
      dirty_cnt = 0;
      drain_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.r.x  = out_x;
        got.r.y  = out_y;
        got.r.w  = out_width;
        got.r.h  = out_height;
        got.last = out_last;
        if (drain_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected rect x=%0d y=%0d w=%0d h=%0d last=%0b", $realtime,
                     got.r.x, got.r.y, got.r.w, got.r.h, got.last);
        end else begin
          want = drain_q.pop_front();
          if (got.r.x !== want.r.x || got.r.y !== want.r.y || got.r.w !== want.r.w ||
              got.r.h !== want.r.h || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: exp %0d,%0d,%0d,%0d,%0b got %0d,%0d,%0d,%0d,%0b",
                       $realtime, want.r.x, want.r.y, want.r.w, want.r.h, want.last,
                       got.r.x, got.r.y, got.r.w, got.r.h, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == OP_FLUSH) begin
          table_flush();
        end else begin
          table_add('{x: in_rect_x, y: in_rect_y, w: in_rect_width, h: in_rect_height});
        end
      end
    end
    pending = drain_q.size();
  end

endmodule

### tb/tb_dirty_rectangle_coalescer.sv
// Top of the dirty rectangle coalescer bench: clock, reset, add/flush stimulus and stall pattern.
// Depends on drc_pkg, dirty_rectangle_coalescer and drc_rect_checker, which does the checking.
module tb_dirty_rectangle_coalescer;
  timeunit 1ns;
  timeprecision 1ps;
  import drc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned CALM_TAIL    = 60;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE       = 2 * MAX_RECTS + 16;

  logic           clk            = 1'b0;
  logic           rst_n          = 1'b0;
  logic           in_valid       = 1'b0;
  logic           in_op          = OP_ADD;
  logic [X_W-1:0] in_rect_x      = '0;
  logic [Y_W-1:0] in_rect_y      = '0;
  logic [W_W-1:0] in_rect_width  = '0;
  logic [H_W-1:0] in_rect_height = '0;
  logic           out_stall      = 1'b0;
  logic           in_stall;
  logic           out_valid;
  logic [X_W-1:0] out_x;
  logic [Y_W-1:0] out_y;
  logic [W_W-1:0] out_width;
  logic [H_W-1:0] out_height;
  logic           out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles     = 0;
  int unsigned rand_sent  = 0;
  int unsigned stall_left = 0;
  logic        calm       = 1'b0;

  always #5ns clk = ~clk;

  dirty_rectangle_coalescer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_last       (out_last)
  );

  drc_rect_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input logic op, input logic [X_W-1:0] x,
                              input logic [Y_W-1:0] y, input logic [W_W-1:0] w,
                              input logic [H_W-1:0] h);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_op          <= op;
    in_rect_x      <= x;
    in_rect_y      <= y;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic add_rect(input int unsigned x, input int unsigned y, input int unsigned w,
                          input int unsigned h);
    send_request(OP_ADD, x[X_W-1:0], y[Y_W-1:0], w[W_W-1:0], h[H_W-1:0]);
  endtask

  task automatic flush_table();
    send_request(OP_FLUSH, X_W'($urandom), Y_W'($urandom), W_W'($urandom), H_W'($urandom));
  endtask

  // random-phase request: counts towards the random total and ends idling near the end
  task automatic rand_request(input logic op, input int unsigned x, input int unsigned y,
                              input int unsigned w, input int unsigned h);
    if (op == OP_FLUSH) flush_table();
    else add_rect(x, y, w, h);
    rand_sent++;
    if (rand_sent + CALM_TAIL >= RANDOM_ITEMS) calm = 1'b1;
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty flush, zero size, saturation, inclusive edges, chained merges
    flush_table();
    add_rect(0, 0, 0, 0);
    add_rect(0, 0, 0, 0);
    add_rect(1023, 511, 0, 0);
    add_rect(1023, 511, 2047, 1023);
    flush_table();
    add_rect(100, 100, 10, 10);
    add_rect(110, 110, 5, 5);
    add_rect(116, 100, 3, 3);
    add_rect(200, 50, 0, 20);
    add_rect(200, 70, 30, 0);
    add_rect(0, 0, 1024, 512);
    flush_table();
    add_rect(5, 5, 1, 1);
    add_rect(50, 50, 1, 1);
    add_rect(3, 3, 60, 60);
    flush_table();
    add_rect(682, 341, 1365, 682);
    add_rect(341, 170, 682, 341);
    flush_table();
    flush_table();

    while (rand_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // scattered small rects: can fill the table and force the fold pass
        len = $urandom_range(1, 40);
        repeat (len)
          rand_request(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 511),
                       $urandom_range(0, 3), $urandom_range(0, 3));
        rand_request(OP_FLUSH, 0, 0, 0, 0);
      end else if (kind <= 7) begin
        len = $urandom_range(1, 12);
        repeat (len)
          rand_request(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 511),
                       $urandom_range(0, 300), $urandom_range(0, 200));
        rand_request(OP_FLUSH, 0, 0, 0, 0);
      end else if (kind == 8) begin
        len = $urandom_range(1, 10);
        repeat (len)
          rand_request(($urandom_range(0, 3) == 0) ? OP_FLUSH : OP_ADD,
                       $urandom_range(0, 1023), $urandom_range(0, 511),
                       $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) rand_request(OP_FLUSH, 0, 0, 0, 0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/drc_pkg.sv
rtl/drc_ram.sv
rtl/drc_datapath.sv
rtl/drc_ctrl.sv
rtl/dirty_rectangle_coalescer.sv
rtl/drc_checker.sv
tb/drc_rect_checker.sv
tb/tb_dirty_rectangle_coalescer.sv
